// File: rtl/core/assert_macros.svh
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, disabled while reset is asserted.
`define VAP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define VAP_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: rtl/core/vap_pkg.sv
// Types, codes and constants of the VT52/ANSI escape parser.
`timescale 1ns / 1ps
package vap_pkg;

	// Display command codes on the result stream.
	localparam logic [3:0] ACT_PUT      = 4'd0;
	localparam logic [3:0] ACT_CURSOR   = 4'd1;
	localparam logic [3:0] ACT_CLR_EOS  = 4'd2;
	localparam logic [3:0] ACT_CLR_SCR  = 4'd3;
	localparam logic [3:0] ACT_CLR_EOL  = 4'd4;
	localparam logic [3:0] ACT_CLR_LINE = 4'd5;
	localparam logic [3:0] ACT_INS_LINE = 4'd6;
	localparam logic [3:0] ACT_DEL_LINE = 4'd7;
	localparam logic [3:0] ACT_COLOR    = 4'd8;

	// Bytes with a meaning to the parser.
	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_7        = 8'h37;
	localparam logic [7:0] CH_8        = 8'h38;
	localparam logic [7:0] CH_A        = 8'h41;
	localparam logic [7:0] CH_B        = 8'h42;
	localparam logic [7:0] CH_C        = 8'h43;
	localparam logic [7:0] CH_D        = 8'h44;
	localparam logic [7:0] CH_H        = 8'h48;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_J        = 8'h4A;
	localparam logic [7:0] CH_K        = 8'h4B;
	localparam logic [7:0] CH_L        = 8'h4C;
	localparam logic [7:0] CH_M        = 8'h4D;
	localparam logic [7:0] CH_Y        = 8'h59;
	localparam logic [7:0] CH_Z        = 8'h5A;
	localparam logic [7:0] CH_F_LC     = 8'h66;
	localparam logic [7:0] CH_M_LC     = 8'h6D;
	localparam logic [7:0] CH_SLASH    = 8'h2F;

	// ESC Y operands are offset by this bias.
	localparam logic [8:0] YPOS_BIAS = 9'd33;

	// Select graphic rendition parameter ranges and defaults.
	localparam logic [15:0] SGR_FG_LO  = 16'd30;
	localparam logic [15:0] SGR_FG_HI  = 16'd37;
	localparam logic [15:0] SGR_BG_LO  = 16'd40;
	localparam logic [15:0] SGR_BG_HI  = 16'd47;
	localparam logic [2:0]  FG_DEFAULT = 3'd7;
	localparam logic [2:0]  BG_DEFAULT = 3'd0;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_YPOS,
		MODE_CSI
	} vap_mode_t;

	typedef enum logic {
		FR_IDLE,
		FR_SGR
	} vap_fr_state_t;

	// Commands passed from the parser front to the executing back end.
	typedef enum logic [3:0] {
		OP_PUT,
		OP_ZID,
		OP_CMD,
		OP_CUR,
		OP_UP,
		OP_DOWN,
		OP_RIGHT,
		OP_LEFT,
		OP_HOME,
		OP_YPOS,
		OP_KLINE,
		OP_COLOR,
		OP_RESTORE
	} vap_op_t;

	typedef struct packed {
		vap_op_t     op;
		logic [3:0]  act;
		logic        stop_at_edge;
		logic [7:0]  ch;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  attr;
		logic [15:0] n;
		logic [15:0] m;
	} vap_pkt_t;

	typedef struct packed {
		logic [3:0] act;
		logic [7:0] ch;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] attr;
	} vap_res_t;

	// ANSI color index to VGA color index.
	function automatic logic [2:0] ansi_to_vga(input logic [2:0] idx);
		logic [2:0] v;
		unique case (idx)
			3'd0: v = 3'd0;
			3'd1: v = 3'd4;
			3'd2: v = 3'd2;
			3'd3: v = 3'd6;
			3'd4: v = 3'd1;
			3'd5: v = 3'd5;
			3'd6: v = 3'd3;
			3'd7: v = 3'd7;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/vap_queue.sv
// Two-entry command queue between the parser front and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vap_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vap_pkg::vap_pkt_t din,
	output logic              full,
	input  logic              pop,
	output vap_pkg::vap_pkt_t dout,
	output logic              empty
);
	import vap_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	vap_pkt_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	`VAP_NEVER(a_no_push_full, clk, arst_n, push && full, "command pushed into a full queue")
	`VAP_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "command popped from an empty queue")
	`VAP_ASSERT(a_pop_frees, clk, arst_n, (pop && !push) |=> !full, "queue still full after a pop")

endmodule

// File: rtl/core/vap_front.sv
// Parser front: accepts bytes, tracks escape state and issues display commands.
`timescale 1ns / 1ps
module vap_front #(
	parameter int MAX_ARGS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,
	output logic              pkt_vld,
	output vap_pkg::vap_pkt_t pkt,
	input  logic              pkt_rdy
);
	import vap_pkg::*;

	localparam int IW = $clog2(MAX_ARGS);
	localparam logic [IW:0] MAXA = (IW+1)'(MAX_ARGS);

	vap_fr_state_t st_q, st_d;
	vap_mode_t     mode_q, mode_d;
	logic [IW-1:0] aidx_q, aidx_d;
	logic [15:0]   cur_q, cur_d;
	logic [15:0]   args_q [MAX_ARGS];
	logic          arg_we;
	logic          yhave_q, yhave_d;
	logic [7:0]    yrow_q, yrow_d;
	logic [7:0]    sv_col_q, sv_row_q, sv_attr_q;
	logic          save_en;
	logic [IW-1:0] widx_q, widx_d;
	logic [2:0]    fg_q, fg_d, bg_q, bg_d;
	logic [2:0]    fg_n, bg_n;
	vap_pkt_t      pkt_q, np;
	logic          pkt_vld_q, np_vld;

	logic [7:0]    c, x, y, a;
	logic          accept;
	logic [15:0]   p0, p1, mv, wv;
	logic [19:0]   acc;
	logic [15:0]   acc_sat;
	logic          is_digit, semi_ok, sgr_last;

	function automatic vap_pkt_t mk_pkt(input vap_op_t op, input logic [3:0] act,
		input logic stop, input logic [7:0] ch, input logic [7:0] col,
		input logic [7:0] row, input logic [7:0] attr, input logic [15:0] n,
		input logic [15:0] m);
		vap_pkt_t p;
		p.op           = op;
		p.act          = act;
		p.stop_at_edge = stop;
		p.ch           = ch;
		p.col          = col;
		p.row          = row;
		p.attr         = attr;
		p.n            = n;
		p.m            = m;
		return p;
	endfunction

	assign c      = s_tdata[7:0];
	assign x      = s_tdata[15:8];
	assign y      = s_tdata[23:16];
	assign a      = s_tdata[31:24];
	assign accept = s_tvalid && s_tready;

	// The slot being typed lives in cur_q; earlier slots are in args_q.
	assign p0 = (aidx_q == '0) ? cur_q : args_q[0];
	assign p1 = (aidx_q == '0) ? 16'd0 : ((aidx_q == IW'(1)) ? cur_q : args_q[1]);
	assign mv = (p0 != 16'd0) ? p0 : 16'd1;

	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign acc      = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1) + 20'(c - CH_0);
	assign acc_sat  = (acc > 20'h0FFFF) ? 16'hFFFF : acc[15:0];
	assign semi_ok  = (({1'b0, aidx_q} + 1'b1) < MAXA);

	assign wv       = (widx_q == aidx_q) ? cur_q : args_q[widx_q];
	assign sgr_last = (widx_q == aidx_q);

	always_comb begin
		fg_n = fg_q;
		bg_n = bg_q;
		priority if (wv == 16'd0) begin
			fg_n = FG_DEFAULT;
			bg_n = BG_DEFAULT;
		end else if (wv >= SGR_FG_LO && wv <= SGR_FG_HI) begin
			fg_n = ansi_to_vga(3'(wv - SGR_FG_LO));
		end else if (wv >= SGR_BG_LO && wv <= SGR_BG_HI) begin
			bg_n = ansi_to_vga(3'(wv - SGR_BG_LO));
		end else begin
			// Any other parameter leaves both colors as they are.
			fg_n = fg_q;
			bg_n = bg_q;
		end
	end

	always_comb begin : next_state
		st_d    = st_q;
		mode_d  = mode_q;
		aidx_d  = aidx_q;
		cur_d   = cur_q;
		yhave_d = yhave_q;
		yrow_d  = yrow_q;
		widx_d  = widx_q;
		fg_d    = fg_q;
		bg_d    = bg_q;
		save_en = 1'b0;
		arg_we  = 1'b0;
		np_vld  = 1'b0;
		np      = '0;
		unique case (st_q)
			FR_SGR: begin
				fg_d   = fg_n;
				bg_d   = bg_n;
				widx_d = widx_q + 1'b1;
				if (sgr_last) begin
					np_vld = 1'b1;
					np     = mk_pkt(OP_COLOR, ACT_COLOR, 1'b0, 8'd0, 8'd0, 8'd0,
						{1'b0, bg_n, 1'b0, fg_n}, 16'd0, 16'd0);
					st_d   = FR_IDLE;
					mode_d = MODE_NORMAL;
					aidx_d = '0;
					cur_d  = '0;
				end
			end
			FR_IDLE: begin
				if (accept) begin
					unique case (mode_q)
						MODE_NORMAL: begin
							if (c == CH_ESC) begin
								mode_d = MODE_ESC;
							end else begin
								np_vld = 1'b1;
								np     = mk_pkt(OP_PUT, ACT_PUT, 1'b0, c, 8'd0, 8'd0, 8'd0,
									16'd0, 16'd0);
							end
						end
						MODE_ESC: begin
							mode_d = MODE_NORMAL;
							aidx_d = '0;
							cur_d  = '0;
							unique case (c)
								CH_A: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_UP, ACT_CURSOR, 1'b1, 8'd0, x, y, 8'd0,
										16'd1, 16'd0);
								end
								CH_B: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_DOWN, ACT_CURSOR, 1'b1, 8'd0, x, y, 8'd0,
										16'd1, 16'd0);
								end
								CH_C: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_RIGHT, ACT_CURSOR, 1'b1, 8'd0, x, y, 8'd0,
										16'd1, 16'd0);
								end
								CH_D: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_LEFT, ACT_CURSOR, 1'b1, 8'd0, x, y, 8'd0,
										16'd1, 16'd0);
								end
								CH_H: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_CUR, ACT_CURSOR, 1'b0, 8'd0, 8'd0, 8'd0,
										8'd0, 16'd0, 16'd0);
								end
								CH_I: begin
									// Reverse line feed scrolls when already on the top row.
									np_vld = 1'b1;
									if (y != 8'd0) begin
										np = mk_pkt(OP_UP, ACT_CURSOR, 1'b1, 8'd0, x, y, 8'd0,
											16'd1, 16'd0);
									end else begin
										np = mk_pkt(OP_CMD, ACT_INS_LINE, 1'b0, 8'd0, 8'd0,
											8'd0, 8'd0, 16'd0, 16'd0);
									end
								end
								CH_J: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_CMD, ACT_CLR_EOS, 1'b0, 8'd0, 8'd0, 8'd0,
										8'd0, 16'd0, 16'd0);
								end
								CH_K: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_CMD, ACT_CLR_EOL, 1'b0, 8'd0, 8'd0, 8'd0,
										8'd0, 16'd0, 16'd0);
								end
								CH_L: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_CMD, ACT_INS_LINE, 1'b0, 8'd0, 8'd0, 8'd0,
										8'd0, 16'd0, 16'd0);
								end
								CH_M: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_CMD, ACT_DEL_LINE, 1'b0, 8'd0, 8'd0, 8'd0,
										8'd0, 16'd0, 16'd0);
								end
								CH_Z: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_ZID, ACT_PUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0,
										16'd0, 16'd0);
								end
								CH_7: begin
									save_en = 1'b1;
								end
								CH_8: begin
									np_vld = 1'b1;
									np = mk_pkt(OP_RESTORE, ACT_CURSOR, 1'b0, 8'd0, sv_col_q,
										sv_row_q, sv_attr_q, 16'd0, 16'd0);
								end
								CH_Y: begin
									mode_d  = MODE_YPOS;
									yhave_d = 1'b0;
								end
								CH_LBRACKET: begin
									mode_d = MODE_CSI;
								end
								default: begin
								end
							endcase
						end
						MODE_YPOS: begin
							if (!yhave_q) begin
								yrow_d  = c;
								yhave_d = 1'b1;
							end else begin
								np_vld = 1'b1;
								np     = mk_pkt(OP_YPOS, ACT_CURSOR, 1'b0, 8'd0, c, yrow_q,
									8'd0, 16'd0, 16'd0);
								mode_d = MODE_NORMAL;
							end
						end
						MODE_CSI: begin
							priority if (is_digit) begin
								cur_d = acc_sat;
							end else if (c == CH_SEMI) begin
								// A separator past the last slot is dropped.
								if (semi_ok) begin
									arg_we = 1'b1;
									aidx_d = aidx_q + 1'b1;
									cur_d  = '0;
								end
							end else begin
								mode_d = MODE_NORMAL;
								aidx_d = '0;
								cur_d  = '0;
								unique case (c)
									CH_H, CH_F_LC: begin
										np_vld = 1'b1;
										np = mk_pkt(OP_HOME, ACT_CURSOR, 1'b0, 8'd0, 8'd0, 8'd0,
											8'd0, p0, p1);
									end
									CH_A: begin
										np_vld = 1'b1;
										np = mk_pkt(OP_UP, ACT_CURSOR, 1'b0, 8'd0, x, y, 8'd0,
											mv, 16'd0);
									end
									CH_B: begin
										np_vld = 1'b1;
										np = mk_pkt(OP_DOWN, ACT_CURSOR, 1'b0, 8'd0, x, y, 8'd0,
											mv, 16'd0);
									end
									CH_C: begin
										np_vld = 1'b1;
										np = mk_pkt(OP_RIGHT, ACT_CURSOR, 1'b0, 8'd0, x, y,
											8'd0, mv, 16'd0);
									end
									CH_D: begin
										np_vld = 1'b1;
										np = mk_pkt(OP_LEFT, ACT_CURSOR, 1'b0, 8'd0, x, y, 8'd0,
											mv, 16'd0);
									end
									CH_J: begin
										if (p0 == 16'd0) begin
											np_vld = 1'b1;
											np = mk_pkt(OP_CMD, ACT_CLR_EOS, 1'b0, 8'd0, 8'd0,
												8'd0, 8'd0, 16'd0, 16'd0);
										end else if (p0 == 16'd2) begin
											np_vld = 1'b1;
											np = mk_pkt(OP_CMD, ACT_CLR_SCR, 1'b0, 8'd0, 8'd0,
												8'd0, 8'd0, 16'd0, 16'd0);
										end
									end
									CH_K: begin
										if (p0 == 16'd0) begin
											np_vld = 1'b1;
											np = mk_pkt(OP_CMD, ACT_CLR_EOL, 1'b0, 8'd0, 8'd0,
												8'd0, 8'd0, 16'd0, 16'd0);
										end else if (p0 == 16'd2) begin
											np_vld = 1'b1;
											np = mk_pkt(OP_KLINE, ACT_CLR_LINE, 1'b0, 8'd0, 8'd0,
												y, 8'd0, 16'd0, 16'd0);
										end
									end
									CH_M_LC: begin
										// Color is resolved by walking the stored parameters.
										st_d   = FR_SGR;
										widx_d = '0;
										fg_d   = FG_DEFAULT;
										bg_d   = BG_DEFAULT;
										mode_d = MODE_CSI;
										aidx_d = aidx_q;
										cur_d  = cur_q;
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin : outputs
		s_tready = (st_q == FR_IDLE) && (!pkt_vld_q || pkt_rdy);
		pkt_vld  = pkt_vld_q;
		pkt      = pkt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= FR_IDLE;
			mode_q    <= MODE_NORMAL;
			aidx_q    <= '0;
			cur_q     <= '0;
			yhave_q   <= 1'b0;
			sv_col_q  <= '0;
			sv_row_q  <= '0;
			sv_attr_q <= '0;
			pkt_vld_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			mode_q    <= mode_d;
			aidx_q    <= aidx_d;
			cur_q     <= cur_d;
			yhave_q   <= yhave_d;
			pkt_vld_q <= np_vld || (pkt_vld_q && !pkt_rdy);
			if (save_en) begin
				sv_col_q  <= x;
				sv_row_q  <= y;
				sv_attr_q <= a;
			end
		end
	end

	always_ff @(posedge clk) begin
		yrow_q <= yrow_d;
		widx_q <= widx_d;
		fg_q   <= fg_d;
		bg_q   <= bg_d;
		if (arg_we) begin
			args_q[aidx_q] <= cur_q;
		end
		if (np_vld) begin
			pkt_q <= np;
		end
	end

endmodule

// File: rtl/core/vap_back.sv
// Back end: turns queued commands into zero, one or two result transactions.
`timescale 1ns / 1ps
module vap_back #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pkt_vld,
	input  vap_pkg::vap_pkt_t pkt,
	output logic              pkt_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output vap_pkg::vap_res_t res,
	output logic              res_last
);
	import vap_pkg::*;

	localparam logic [8:0]  ROWS9   = 9'(SCREEN_ROWS);
	localparam logic [8:0]  COLS9   = 9'(SCREEN_COLS);
	localparam logic [16:0] ROWS17  = 17'(SCREEN_ROWS);
	localparam logic [16:0] COLS17  = 17'(SCREEN_COLS);
	localparam logic [7:0]  ROW_MAX = 8'(SCREEN_ROWS - 1);
	localparam logic [7:0]  COL_MAX = 8'(SCREEN_COLS - 1);

	vap_res_t    r0, r1;
	logic [1:0]  cnt;
	vap_res_t    r0_s1, r1_s1;
	logic [1:0]  cnt_s1;
	logic        vld_s1;
	logic        phase_q;
	logic        m_vld_q;
	vap_res_t    res_q;
	logic        last_q;

	logic        up_clamp, left_clamp, down_clamp, right_clamp;
	logic [16:0] down_sum, right_sum;
	logic [15:0] home_r, home_c;
	logic [7:0]  home_row, home_col;
	logic [8:0]  yp_r, yp_c;
	logic        yp_ok;
	logic        out_free, last_now, emit, fin;

	assign up_clamp    = pkt.n > {8'd0, pkt.row};
	assign left_clamp  = pkt.n > {8'd0, pkt.col};
	assign down_sum    = {9'd0, pkt.row} + {1'b0, pkt.n};
	assign right_sum   = {9'd0, pkt.col} + {1'b0, pkt.n};
	assign down_clamp  = down_sum >= ROWS17;
	assign right_clamp = right_sum >= COLS17;

	assign home_r   = (pkt.n != 16'd0) ? pkt.n - 16'd1 : 16'd0;
	assign home_c   = (pkt.m != 16'd0) ? pkt.m - 16'd1 : 16'd0;
	assign home_row = (home_r >= 16'(SCREEN_ROWS)) ? ROW_MAX : home_r[7:0];
	assign home_col = (home_c >= 16'(SCREEN_COLS)) ? COL_MAX : home_c[7:0];

	assign yp_r  = {1'b0, pkt.row} - YPOS_BIAS;
	assign yp_c  = {1'b0, pkt.col} - YPOS_BIAS;
	assign yp_ok = ({1'b0, pkt.row} >= YPOS_BIAS) && (yp_r < ROWS9) &&
		({1'b0, pkt.col} >= YPOS_BIAS) && (yp_c < COLS9);

	// Results of the command at the queue head.
	always_comb begin
		r0  = '0;
		r1  = '0;
		cnt = 2'd1;
		unique case (pkt.op)
			OP_PUT: begin
				r0.act = ACT_PUT;
				r0.ch  = pkt.ch;
			end
			OP_ZID: begin
				r0.act = ACT_PUT;
				r0.ch  = CH_SLASH;
				r1.act = ACT_PUT;
				r1.ch  = CH_K;
				cnt    = 2'd2;
			end
			OP_CMD: begin
				r0.act = pkt.act;
			end
			OP_CUR: begin
				r0.act = ACT_CURSOR;
				r0.col = pkt.col;
				r0.row = pkt.row;
			end
			OP_UP: begin
				r0.act = ACT_CURSOR;
				r0.col = pkt.col;
				r0.row = up_clamp ? 8'd0 : pkt.row - pkt.n[7:0];
				cnt    = (pkt.stop_at_edge && up_clamp) ? 2'd0 : 2'd1;
			end
			OP_DOWN: begin
				r0.act = ACT_CURSOR;
				r0.col = pkt.col;
				r0.row = down_clamp ? ROW_MAX : down_sum[7:0];
				cnt    = (pkt.stop_at_edge && down_clamp) ? 2'd0 : 2'd1;
			end
			OP_RIGHT: begin
				r0.act = ACT_CURSOR;
				r0.col = right_clamp ? COL_MAX : right_sum[7:0];
				r0.row = pkt.row;
				cnt    = (pkt.stop_at_edge && right_clamp) ? 2'd0 : 2'd1;
			end
			OP_LEFT: begin
				r0.act = ACT_CURSOR;
				r0.col = left_clamp ? 8'd0 : pkt.col - pkt.n[7:0];
				r0.row = pkt.row;
				cnt    = (pkt.stop_at_edge && left_clamp) ? 2'd0 : 2'd1;
			end
			OP_HOME: begin
				r0.act = ACT_CURSOR;
				r0.col = home_col;
				r0.row = home_row;
			end
			OP_YPOS: begin
				r0.act = ACT_CURSOR;
				r0.col = yp_c[7:0];
				r0.row = yp_r[7:0];
				cnt    = yp_ok ? 2'd1 : 2'd0;
			end
			OP_KLINE: begin
				r0.act = ACT_CLR_LINE;
				r0.row = pkt.row;
				r1.act = ACT_CURSOR;
				r1.row = pkt.row;
				cnt    = 2'd2;
			end
			OP_COLOR: begin
				r0.act  = ACT_COLOR;
				r0.attr = pkt.attr;
			end
			OP_RESTORE: begin
				r0.act  = ACT_CURSOR;
				r0.col  = pkt.col;
				r0.row  = pkt.row;
				r1.act  = ACT_COLOR;
				r1.attr = pkt.attr;
				cnt     = 2'd2;
			end
			default: begin
				cnt = 2'd0;
			end
		endcase
	end

	assign out_free = !m_vld_q || m_tready;
	assign last_now = (cnt_s1 == 2'd1) || phase_q;
	assign emit     = vld_s1 && (cnt_s1 != 2'd0) && out_free;
	assign fin      = vld_s1 && ((cnt_s1 == 2'd0) || (emit && last_now));
	assign pkt_pop  = pkt_vld && (!vld_s1 || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			phase_q <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			if (pkt_pop) begin
				vld_s1 <= 1'b1;
			end else if (fin) begin
				vld_s1 <= 1'b0;
			end
			if (fin) begin
				phase_q <= 1'b0;
			end else if (emit) begin
				phase_q <= 1'b1;
			end
			if (emit) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_pop) begin
			r0_s1  <= r0;
			r1_s1  <= r1;
			cnt_s1 <= cnt;
		end
		if (emit) begin
			res_q  <= phase_q ? r1_s1 : r0_s1;
			last_q <= last_now;
		end
	end

	assign m_tvalid = m_vld_q;
	assign res      = res_q;
	assign res_last = last_q;

endmodule

// File: rtl/core/vt52_ansi_escape_parser_core.sv
// Top level of the VT52 escape parser with ANSI CSI support.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  terminal byte with cursor column, row and attribute
//  m_*      out  m_tvalid/m_tready  display command, m_tlast on the last one of a byte
//
// A byte is taken when the front is idle and its command register is free; its
// commands pass through the front register, queue, back-end stage and result register.
// An SGR final byte holds s_tready low while the front walks the stored
// parameters, one per cycle, and takes no new byte until the walk ends.
// ESC Z, ESC 8 and CSI 2 K give two transactions, one per cycle while m_tready is high.
// Reset clears the parse state and the saved cursor; no clearing pass is needed.
// A stalled output fills the two-entry queue before s_tready drops.
`timescale 1ns / 1ps
module vt52_ansi_escape_parser_core #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25,
	parameter int MAX_ARGS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_byte, cursor_col, cursor_row, current_attr
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // action(4), out_char, out_col, out_row, out_attr, pad
	output logic        m_tlast
);
	import vap_pkg::*;

	logic     fr_vld;
	vap_pkt_t fr_pkt;
	logic     q_full;
	logic     q_empty;
	vap_pkt_t q_head;
	logic     q_pop;
	vap_res_t res;

	vap_front #(
		.MAX_ARGS(MAX_ARGS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.pkt_vld  (fr_vld),
		.pkt      (fr_pkt),
		.pkt_rdy  (!q_full)
	);

	vap_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_vld && !q_full),
		.din    (fr_pkt),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	vap_back #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_vld  (!q_empty),
		.pkt      (q_head),
		.pkt_pop  (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res),
		.res_last (m_tlast)
	);

	assign m_tdata = {4'd0, res.attr, res.row, res.col, res.ch, res.act};

endmodule
